/* rtl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Shared types and constants for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int unsigned COUNT_BITS_DEFAULT = 16;
   localparam int unsigned CSR_ADDR_BITS      = 1;

   localparam logic [7:0] CHAR_PAD     = 8'd61;
   localparam logic [7:0] CHAR_UPPER_A = 8'd65;
   localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [7:0] CHAR_LOWER_A = 8'd97;
   localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'd48;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'd57;

   localparam logic [7:0] DIGIT62_RESET = 8'd43;
   localparam logic [7:0] DIGIT63_RESET = 8'd47;

   localparam logic [5:0] DIGIT_LOWER_BASE = 6'd26;
   localparam logic [5:0] DIGIT_NUM_BASE   = 6'd52;
   localparam logic [5:0] DIGIT_62         = 6'd62;
   localparam logic [5:0] DIGIT_63         = 6'd63;

   localparam logic [15:0] BYTE_COUNT_MAX = 16'hffff;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_DIGIT62 = 1'b0,
      CSR_DIGIT63 = 1'b1
   } csr_addr_type;

   typedef enum logic [1:0] {
      QUAD_POS0 = 2'd0,
      QUAD_POS1 = 2'd1,
      QUAD_POS2 = 2'd2,
      QUAD_POS3 = 2'd3
   } quad_pos_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic       is_pad;
      logic       is_bad;
      logic [5:0] digit;
   } char_class_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        done_res;
      logic        error_flag;
      logic [15:0] byte_count;
   } rsp_item_type;

endpackage

/* rtl/b64d_chan_if.sv */
// ----------------------------------------------------------------------------
// Base64 stream decoder channels
// Valid/ready channel interfaces for characters, results and register writes.
// ----------------------------------------------------------------------------
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

interface b64d_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        done_res;
   logic        error_flag;
   logic [15:0] byte_count;

   modport source (output valid, output out_byte, output byte_valid, output done_res,
                   output error_flag, output byte_count, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input done_res,
                   input error_flag, input byte_count, output ready);
endinterface

interface b64d_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] addr;
   logic [7:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

/* rtl/b64d_in_stage.sv */
// ----------------------------------------------------------------------------
// Input register
// Holds one character item until the decode step consumes it.
// ----------------------------------------------------------------------------
module b64d_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   b64d_req_if.sink               req_bus,
   input  logic                   consume,
   output logic                   held_valid,
   output b64d_pkg::req_item_type held_item
);
   import b64d_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   assign req_bus.ready = !valid_ff || consume;
   assign load          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (consume) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.ch   <= req_bus.ch;
         item_ff.last <= req_bus.last;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

/* rtl/b64d_classify.sv */
// ----------------------------------------------------------------------------
// Character classifier
// Maps a character code to a 6-bit digit, padding or invalid.
// ----------------------------------------------------------------------------
module b64d_classify (
   input  logic [7:0]               ch,
   input  logic [7:0]               digit62_char,
   input  logic [7:0]               digit63_char,
   output b64d_pkg::char_class_type char_class
);
   import b64d_pkg::*;

   logic [7:0] upper_off;
   logic [7:0] lower_off;
   logic [7:0] num_off;

   assign upper_off = ch - CHAR_UPPER_A;
   assign lower_off = ch - CHAR_LOWER_A;
   assign num_off   = ch - CHAR_DIGIT_0;

   always_comb begin
      char_class.is_pad = 1'b0;
      char_class.is_bad = 1'b0;
      char_class.digit  = '0;
      if (ch == CHAR_PAD) begin
         char_class.is_pad = 1'b1;
      end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
         char_class.digit = upper_off[5:0];
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
         char_class.digit = lower_off[5:0] + DIGIT_LOWER_BASE;
      end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
         char_class.digit = num_off[5:0] + DIGIT_NUM_BASE;
      end else if (ch == digit62_char) begin
         char_class.digit = DIGIT_62;
      end else if (ch == digit63_char) begin
         char_class.digit = DIGIT_63;
      end else begin
         char_class.is_bad = 1'b1;
      end
   end

endmodule

/* rtl/b64d_step.sv */
// ----------------------------------------------------------------------------
// Decode step
// Stream state, byte assembly, error checks and the result register.
// ----------------------------------------------------------------------------
module b64d_step #(
   parameter int unsigned COUNT_BITS = b64d_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     held_valid,
   input  b64d_pkg::req_item_type   held_item,
   input  b64d_pkg::char_class_type char_class,
   output logic                     consume,
   b64d_rsp_if.source               rsp_bus
);
   import b64d_pkg::*;

   localparam int unsigned EXT_BITS = COUNT_BITS + 16;

   logic [5:0]            bits_ff, bits_in;
   quad_pos_type          pos_ff, pos_in;
   logic [1:0]            pad_ff, pad_in;
   logic                  bad_ff, bad_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;

   logic [5:0]            bits_nx;
   quad_pos_type          pos_nx;
   logic [1:0]            pad_nx;
   logic                  bad_nx;
   logic [COUNT_BITS-1:0] total_nx;
   logic                  have_byte;
   logic [7:0]            byte_val;

   logic                  out_valid_ff, out_valid_in;
   rsp_item_type          out_item_ff, out_item_in;

   logic                  emit;
   logic                  load_ok;
   logic                  stream_err;
   logic [EXT_BITS-1:0]   total_ext;

   always_comb begin
      bits_nx   = bits_ff;
      pos_nx    = pos_ff;
      pad_nx    = pad_ff;
      bad_nx    = bad_ff;
      total_nx  = total_ff;
      have_byte = 1'b0;
      byte_val  = '0;
      if (!bad_ff) begin
         if (char_class.is_bad) begin
            bad_nx = 1'b1;
         end else if (char_class.is_pad) begin
            if (pos_ff == QUAD_POS0 || pos_ff == QUAD_POS1) begin
               bad_nx = 1'b1;
            end else if (pos_ff == QUAD_POS2) begin
               if (pad_ff != 2'd0) begin
                  bad_nx = 1'b1;
               end else begin
                  pad_nx = 2'd1;
               end
            end else begin
               pad_nx = pad_ff + 2'd1;
            end
         end else if (pad_ff != 2'd0) begin
            bad_nx = 1'b1;
         end else begin
            case (pos_ff)
               QUAD_POS0: begin
                  bits_nx = char_class.digit;
               end
               QUAD_POS1: begin
                  byte_val  = {bits_ff, char_class.digit[5:4]};
                  bits_nx   = {2'b00, char_class.digit[3:0]};
                  have_byte = 1'b1;
               end
               QUAD_POS2: begin
                  byte_val  = {bits_ff[3:0], char_class.digit[5:2]};
                  bits_nx   = {4'b0000, char_class.digit[1:0]};
                  have_byte = 1'b1;
               end
               default: begin
                  byte_val  = {bits_ff[1:0], char_class.digit};
                  bits_nx   = '0;
                  have_byte = 1'b1;
               end
            endcase
            if (have_byte && total_ff != '1) begin
               total_nx = total_ff + 1'b1;
            end
         end
         if (!bad_nx && pos_ff == QUAD_POS3 && pad_nx != 2'd0) begin
            pad_nx = pad_nx | 2'd1;
         end
         pos_nx = quad_pos_type'(pos_ff + 2'd1);
      end
   end

   assign stream_err = bad_nx || pos_nx != QUAD_POS0;
   assign total_ext  = {16'b0, total_nx};

   always_comb begin
      out_item_in.out_byte   = byte_val;
      out_item_in.byte_valid = have_byte;
      out_item_in.done_res   = held_item.last;
      out_item_in.error_flag = held_item.last && stream_err;
      out_item_in.byte_count = '0;
      if (held_item.last && !stream_err) begin
         if (total_ext > EXT_BITS'(BYTE_COUNT_MAX)) begin
            out_item_in.byte_count = BYTE_COUNT_MAX;
         end else begin
            out_item_in.byte_count = total_ext[15:0];
         end
      end
   end

   assign emit    = held_valid && (held_item.last || have_byte);
   assign load_ok = !out_valid_ff || rsp_bus.ready;
   assign consume = held_valid && (!emit || load_ok);

   always_comb begin
      bits_in  = bits_ff;
      pos_in   = pos_ff;
      pad_in   = pad_ff;
      bad_in   = bad_ff;
      total_in = total_ff;
      if (consume) begin
         if (held_item.last) begin
            bits_in  = '0;
            pos_in   = QUAD_POS0;
            pad_in   = '0;
            bad_in   = 1'b0;
            total_in = '0;
         end else begin
            bits_in  = bits_nx;
            pos_in   = pos_nx;
            pad_in   = pad_nx;
            bad_in   = bad_nx;
            total_in = total_nx;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (consume && emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff      <= '0;
         pos_ff       <= QUAD_POS0;
         pad_ff       <= '0;
         bad_ff       <= 1'b0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         bits_ff      <= bits_in;
         pos_ff       <= pos_in;
         pad_ff       <= pad_in;
         bad_ff       <= bad_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && emit) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.out_byte   = out_item_ff.out_byte;
   assign rsp_bus.byte_valid = out_item_ff.byte_valid;
   assign rsp_bus.done_res   = out_item_ff.done_res;
   assign rsp_bus.error_flag = out_item_ff.error_flag;
   assign rsp_bus.byte_count = out_item_ff.byte_count;

endmodule

/* rtl/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes one base64 character per item, emits each byte as it completes
// and reports status and byte count on the last character.
//
//   channel   direction  payload
//   req_bus   in         ch[7:0], last
//   rsp_bus   out        out_byte[7:0], byte_valid, done_res, error_flag,
//                        byte_count[15:0]
//   csr_bus   in         addr (0: digit62_char, 1: digit63_char), wdata[7:0]
//
// One item per cycle sustained while the result register does not stall; a
// character passes the input register, then decode, into the result register.
// Reset clears the stream state and loads '+' and '/' as the symbol codes.
// A stalled result register holds the decode step; the input register still
// takes one item, and items that yield no result pass while it stalls.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
   parameter int unsigned COUNT_BITS = b64d_pkg::COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   b64d_req_if.sink    req_bus,
   b64d_rsp_if.source  rsp_bus,
   b64d_csr_if.sink    csr_bus
);
   import b64d_pkg::*;

   logic [7:0]     digit62_ff, digit62_in;
   logic [7:0]     digit63_ff, digit63_in;
   logic           csr_write;

   logic           held_valid;
   req_item_type   held_item;
   char_class_type char_class;
   logic           consume;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      digit62_in = digit62_ff;
      digit63_in = digit63_ff;
      if (csr_write) begin
         unique case (csr_addr_type'(csr_bus.addr))
            CSR_DIGIT62: digit62_in = csr_bus.wdata;
            CSR_DIGIT63: digit63_in = csr_bus.wdata;
            default: begin
               digit62_in = digit62_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit62_ff <= DIGIT62_RESET;
         digit63_ff <= DIGIT63_RESET;
      end else begin
         digit62_ff <= digit62_in;
         digit63_ff <= digit63_in;
      end
   end

   b64d_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .consume    (consume),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   b64d_classify u_classify (
      .ch           (held_item.ch),
      .digit62_char (digit62_ff),
      .digit63_char (digit63_ff),
      .char_class   (char_class)
   );

   b64d_step #(
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .held_valid (held_valid),
      .held_item  (held_item),
      .char_class (char_class),
      .consume    (consume),
      .rsp_bus    (rsp_bus)
   );

endmodule
